// File: src/tga_pkg.sv
package tga_pkg;

   // Header layout
   localparam int HDR_LEN = 12;
   localparam logic [7:0] RAW_PATTERN [HDR_LEN] = '{
      8'd0, 8'd0, 8'd2, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
   };
   localparam logic [7:0] RLE_PATTERN [HDR_LEN] = '{
      8'd0, 8'd0, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
   };
   localparam logic [3:0] HDR_LAST = 4'(HDR_LEN - 1);

   localparam logic [7:0] BPP_24   = 8'd24;
   localparam logic [7:0] BPP_32   = 8'd32;
   localparam logic [7:0] RUN_BIAS = 8'd127;

   // Result kinds
   localparam logic [1:0] KIND_INFO  = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_HEADER  = 2'd1;
   localparam logic [1:0] ERR_SIZE    = 2'd2;
   localparam logic [1:0] ERR_OVERRUN = 2'd3;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       start_of_file;
   } tga_req_type;

   typedef struct packed {
      logic [1:0]  item_kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [7:0]  bits_per_pixel;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_count;
      logic        last_pixel;
      logic [1:0]  error_code;
   } tga_rsp_type;

   // Work passed from the header parser to the pixel engine
   typedef enum logic [1:0] {
      OP_INFO  = 2'd0,
      OP_ERROR = 2'd1,
      OP_DATA  = 2'd2
   } tga_op_type;

   typedef struct packed {
      tga_op_type  op;
      logic [7:0]  val;      // data byte, bpp or error code
      logic [15:0] width;
      logic [15:0] height;
      logic        is_rle;
   } tga_tok_type;

endpackage

// File: src/tga_stream_if.sv
interface tga_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/tga_front.sv
module tga_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 beat_valid,
   input  tga_pkg::tga_req_type beat,
   output logic                 beat_ready,
   output logic                 tok_valid,
   output tga_pkg::tga_tok_type tok,
   input  logic                 tok_ready
);
   import tga_pkg::*;

   typedef enum logic [3:0] {
      FR_HEADER = 4'b0001,
      FR_INFO   = 4'b0010,
      FR_DATA   = 4'b0100,
      FR_IDLE   = 4'b1000
   } fr_phase_type;

   localparam logic [3:0] INFO_W_LO = 4'd0;
   localparam logic [3:0] INFO_W_HI = 4'd1;
   localparam logic [3:0] INFO_H_LO = 4'd2;
   localparam logic [3:0] INFO_H_HI = 4'd3;
   localparam logic [3:0] INFO_BPP  = 4'd4;

   fr_phase_type phase_ff, phase_in, phase_cur;
   logic [3:0]   idx_ff, idx_in, idx_cur;
   logic         mraw_ff, mraw_in, mraw_cur;
   logic         mrle_ff, mrle_in, mrle_cur;
   logic         rle_ff, rle_in, rle_cur;
   logic [15:0]  width_ff, width_in;
   logic [15:0]  height_ff, height_in;
   logic         accept;
   logic         emit;
   logic [7:0]   b;
   logic         raw_ok, rle_ok;

   assign beat_ready = tok_ready;
   assign accept     = beat_valid && tok_ready;
   assign tok_valid  = accept && emit;
   assign b          = beat.file_byte;

   // start of file restarts the parse on this very byte
   always_comb begin
      phase_cur = beat.start_of_file ? FR_HEADER : phase_ff;
      idx_cur   = beat.start_of_file ? 4'd0 : idx_ff;
      mraw_cur  = beat.start_of_file ? 1'b1 : mraw_ff;
      mrle_cur  = beat.start_of_file ? 1'b1 : mrle_ff;
      rle_cur   = beat.start_of_file ? 1'b0 : rle_ff;
   end

   // header match, size capture and token build
   always_comb begin
      phase_in   = phase_cur;
      idx_in     = idx_cur;
      mraw_in    = mraw_cur;
      mrle_in    = mrle_cur;
      rle_in     = rle_cur;
      width_in   = width_ff;
      height_in  = height_ff;
      emit       = 1'b0;
      tok.op     = OP_DATA;
      tok.val    = b;
      tok.width  = width_ff;
      tok.height = height_ff;
      tok.is_rle = rle_cur;
      raw_ok     = mraw_cur && (b == RAW_PATTERN[idx_cur]);
      rle_ok     = mrle_cur && (b == RLE_PATTERN[idx_cur]);
      case (phase_cur)
         FR_HEADER: begin
            mraw_in = raw_ok;
            mrle_in = rle_ok;
            if (idx_cur == HDR_LAST) begin
               idx_in = 4'd0;
               if (!raw_ok && !rle_ok) begin
                  emit     = 1'b1;
                  tok.op   = OP_ERROR;
                  tok.val  = {6'd0, ERR_HEADER};
                  phase_in = FR_IDLE;
               end else begin
                  rle_in   = rle_ok;
                  phase_in = FR_INFO;
               end
            end else begin
               idx_in = idx_cur + 4'd1;
            end
         end
         FR_INFO: begin
            idx_in = idx_cur + 4'd1;
            case (idx_cur)
               INFO_W_LO: width_in[7:0]   = b;
               INFO_W_HI: width_in[15:8]  = b;
               INFO_H_LO: height_in[7:0]  = b;
               INFO_H_HI: height_in[15:8] = b;
               INFO_BPP: begin
                  emit = 1'b1;
                  if (width_ff == 16'd0 || height_ff == 16'd0 ||
                      (b != BPP_24 && b != BPP_32)) begin
                     tok.op   = OP_ERROR;
                     tok.val  = {6'd0, ERR_SIZE};
                     phase_in = FR_IDLE;
                  end else begin
                     tok.op = OP_INFO;
                  end
               end
               default: begin
                  // descriptor byte: ignored, pixel data follows
                  idx_in   = 4'd0;
                  phase_in = FR_DATA;
               end
            endcase
         end
         FR_DATA: begin
            emit = 1'b1;
         end
         FR_IDLE: begin
            emit = 1'b0;
         end
         default: phase_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= FR_HEADER;
         idx_ff   <= 4'd0;
         mraw_ff  <= 1'b1;
         mrle_ff  <= 1'b1;
         rle_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         mraw_ff  <= mraw_in;
         mrle_ff  <= mrle_in;
         rle_ff   <= rle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

endmodule

// File: src/tga_queue.sv
module tga_queue #(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  tga_pkg::tga_tok_type         push_tok,
   output logic                         full,
   output logic [$clog2(DEPTH+1)-1:0]   level,
   input  logic                         pop,
   output logic                         head_valid,
   output tga_pkg::tga_tok_type         head_tok
);
   import tga_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   tga_tok_type      slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [LVL_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full       = (cnt_ff == LVL_W'(DEPTH));
   assign level      = cnt_ff;
   assign head_valid = (cnt_ff != '0);
   assign head_tok   = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and level update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + LVL_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_tok;
      end
   end

endmodule

// File: src/tga_back.sv
module tga_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  tga_pkg::tga_tok_type head_tok,
   output logic                 pop,
   output logic                 out_valid,
   output tga_pkg::tga_rsp_type out_data,
   input  logic                 out_ready
);
   import tga_pkg::*;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_RAW  = 3'b010,
      BK_RLE  = 3'b100
   } bk_phase_type;

   bk_phase_type phase_ff, phase_in;
   logic [31:0]  remain_ff, remain_in;
   logic [7:0]   left_ff, left_in;
   logic         run_ff, run_in;
   logic [1:0]   bip_ff, bip_in;
   logic         is32_ff, is32_in;
   logic [7:0]   col_ff [3];
   logic [7:0]   col_in [3];
   logic         out_valid_ff, out_valid_in;
   tga_rsp_type  out_data_ff;
   tga_rsp_type  res;
   logic         res_valid;
   logic [7:0]   b;
   logic         pix_done;
   logic [7:0]   cnt;
   logic [7:0]   dec;
   logic [31:0]  area;

   assign b         = head_tok.val;
   assign area      = 32'(head_tok.width) * 32'(head_tok.height);
   assign pix_done  = is32_ff ? (bip_ff == 2'd3) : (bip_ff == 2'd2);
   assign cnt       = b[7] ? (b - RUN_BIAS) : (b + 8'd1);
   assign dec       = run_ff ? left_ff : 8'd1;
   assign pop       = head_valid && (!res_valid || !out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // one token of work: info, error, or one data byte (packet header or pixel byte)
   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      left_in   = left_ff;
      run_in    = run_ff;
      bip_in    = bip_ff;
      is32_in   = is32_ff;
      col_in    = col_ff;
      res       = '0;
      res_valid = 1'b0;
      case (head_tok.op)
         OP_INFO: begin
            res_valid          = 1'b1;
            res.item_kind      = KIND_INFO;
            res.image_width    = head_tok.width;
            res.image_height   = head_tok.height;
            res.bits_per_pixel = b;
            phase_in           = head_tok.is_rle ? BK_RLE : BK_RAW;
            remain_in          = area;
            left_in            = 8'd0;
            run_in             = 1'b0;
            bip_in             = 2'd0;
            is32_in            = (b == BPP_32);
         end
         OP_ERROR: begin
            res_valid      = 1'b1;
            res.item_kind  = KIND_ERROR;
            res.error_code = b[1:0];
            phase_in       = BK_IDLE;
         end
         OP_DATA: begin
            if (phase_ff == BK_RLE && left_ff == 8'd0) begin
               // packet header
               if ({24'd0, cnt} > remain_ff) begin
                  res_valid      = 1'b1;
                  res.item_kind  = KIND_ERROR;
                  res.error_code = ERR_OVERRUN;
                  phase_in       = BK_IDLE;
               end else begin
                  left_in = cnt;
                  run_in  = b[7];
                  bip_in  = 2'd0;
               end
            end else if (phase_ff == BK_RAW || phase_ff == BK_RLE) begin
               // pixel byte
               if (bip_ff != 2'd3) begin
                  col_in[bip_ff] = b;
               end
               if (!pix_done) begin
                  bip_in = bip_ff + 2'd1;
               end else begin
                  bip_in           = 2'd0;
                  res_valid        = 1'b1;
                  res.item_kind    = KIND_PIXEL;
                  res.red          = is32_ff ? col_ff[2] : b;
                  res.green        = col_ff[1];
                  res.blue         = col_ff[0];
                  res.alpha        = is32_ff ? b : 8'd0;
                  if (phase_ff == BK_RLE) begin
                     res.repeat_count = dec;
                     res.last_pixel   = (remain_ff == {24'd0, dec});
                     remain_in        = remain_ff - {24'd0, dec};
                     left_in          = run_ff ? 8'd0 : left_ff - 8'd1;
                  end else begin
                     res.repeat_count = 8'd1;
                     res.last_pixel   = (remain_ff == 32'd1);
                     remain_in        = remain_ff - 32'd1;
                  end
                  if (res.last_pixel) begin
                     phase_in = BK_IDLE;
                  end
               end
            end
         end
         default: res_valid = 1'b0;
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop && res_valid) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= BK_IDLE;
         left_ff      <= 8'd0;
         run_ff       <= 1'b0;
         bip_ff       <= 2'd0;
         is32_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
            run_ff   <= run_in;
            bip_ff   <= bip_in;
            is32_ff  <= is32_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         remain_ff <= remain_in;
         col_ff    <= col_in;
      end
      if (pop && res_valid) begin
         out_data_ff <= res;
      end
   end

endmodule

// File: src/tga_image_stream_decoder_unit.sv
// TGA stream decoder: takes one file byte per beat, at a sustained rate of one
// byte per cycle, and gives an info item at the bpp byte of the header, one item
// per pixel (raw data and raw packets) or per run packet, and an error item on a
// bad header, a bad size or bpp, or a packet that runs past width*height. A
// header parser accepts and classifies each byte and hands work through a
// QUEUE_DEPTH-entry queue to the pixel engine, which owns the output register;
// a result is held in a queue slot, then the output register. Input stalls only
// when the queue is full, which happens only while the result side is held off.
module tga_image_stream_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   tga_stream_if.sink  req_chan,
   tga_stream_if.source rsp_chan
);
   import tga_pkg::*;

   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   tga_req_type      req_beat;
   tga_tok_type      push_tok;
   tga_tok_type      head_tok;
   tga_rsp_type      rsp_beat;
   logic             push_valid;
   logic             q_full;
   logic [LVL_W-1:0] q_level;
   logic             head_valid;
   logic             q_pop;
   logic             rsp_valid;

   assign req_beat         = req_chan.payload;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_beat;

   tga_front u_front (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (req_chan.valid),
      .beat       (req_beat),
      .beat_ready (req_chan.ready),
      .tok_valid  (push_valid),
      .tok        (push_tok),
      .tok_ready  (!q_full)
   );

   tga_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_tok   (push_tok),
      .full       (q_full),
      .level      (q_level),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_tok   (head_tok)
   );

   tga_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_tok   (head_tok),
      .pop        (q_pop),
      .out_valid  (rsp_valid),
      .out_data   (rsp_beat),
      .out_ready  (rsp_chan.ready)
   );

   // queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= LVL_W'(QUEUE_DEPTH))
      else $error("queue level above depth");

   // a pixel or run always covers at least one pixel
   a_pixel_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beat.item_kind == KIND_PIXEL |-> rsp_beat.repeat_count != 8'd0)
      else $error("pixel item with zero repeat");

   // only error items carry an error code, and they always do
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_beat.item_kind == KIND_ERROR) == (rsp_beat.error_code != ERR_NONE)))
      else $error("error code does not match item kind");

endmodule
